// ===== rtl/acpm_pkg.sv =====
package acpm_pkg;

    localparam int unsigned SQ_W     = 56;
    localparam int unsigned PS_W     = 57;
    localparam int unsigned CFG_W    = 24;
    localparam int unsigned WL_W     = 16;
    localparam int unsigned PH_W     = 15;
    localparam int unsigned GAIN_W   = 24;
    localparam int unsigned RMS_W    = 32;
    localparam int unsigned RP_W     = 56;
    localparam int unsigned AP_W     = 55;
    localparam int unsigned PF_W     = 16;
    localparam int unsigned MAGQ_W   = 57;
    localparam int unsigned ROOT_W   = 28;
    localparam int unsigned XP_W     = 81;
    localparam int unsigned ACC_W    = 106;
    localparam int unsigned STEP_W   = 6;

    localparam logic [15:0] HP_COEF = 16'd32637;

    localparam logic [STEP_W-1:0] DIV_LAST  = STEP_W'(MAGQ_W - 1);
    localparam logic [STEP_W-1:0] SQRT_LAST = STEP_W'(ROOT_W - 1);
    localparam logic [STEP_W-1:0] PF_LAST   = STEP_W'(13);

    localparam logic [WL_W-1:0]   WL_RESET   = 16'd1000;
    localparam logic [PH_W-1:0]   PH_RESET   = 15'd16384;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    typedef enum logic [1:0] {
        CFG_WINDOW,
        CFG_PHASE,
        CFG_VGAIN,
        CFG_IGAIN
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CH_VOLT,
        CH_AMP,
        CH_POWER
    } chan_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_HPV,
        OP_HPA,
        OP_CAL,
        OP_CALSQ,
        OP_VSQ,
        OP_ASQ,
        OP_PW,
        OP_DIV_LD,
        OP_DIV_STEP,
        OP_SQRT_LD,
        OP_SQRT_STEP,
        OP_RMS_MUL,
        OP_RMS_ST,
        OP_BM1,
        OP_BM2,
        OP_BM3,
        OP_BM4,
        OP_BM5,
        OP_BM6,
        OP_BM7,
        OP_RP,
        OP_AP1,
        OP_AP2,
        OP_AP3,
        OP_AP4,
        OP_APQ,
        OP_PFI,
        OP_PF_STEP,
        OP_OUT
    } dp_op_t;

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_HPV,
        ST_HPA,
        ST_CAL,
        ST_CALSQ,
        ST_VSQ,
        ST_ASQ,
        ST_PW,
        ST_DIV_LD,
        ST_DIV,
        ST_SQRT_LD,
        ST_SQRT,
        ST_RMS_MUL,
        ST_RMS_ST,
        ST_BM1,
        ST_BM2,
        ST_BM3,
        ST_BM4,
        ST_BM5,
        ST_BM6,
        ST_BM7,
        ST_RP,
        ST_AP1,
        ST_AP2,
        ST_AP3,
        ST_AP4,
        ST_APQ,
        ST_PFI,
        ST_PF,
        ST_OUT
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
        chan_t  sel;
    } dp_cmd_t;

    typedef struct packed {
        logic win_end;
        logic out_busy;
    } dp_stat_t;

endpackage

// ===== rtl/acpm_ctrl.sv =====
module acpm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  acpm_pkg::dp_stat_t stat,
    output acpm_pkg::dp_cmd_t  cmd
);
    import acpm_pkg::*;

    ctrl_state_t        state_reg, state_next;
    chan_t              ch_reg, ch_next;
    logic [STEP_W-1:0]  step_reg, step_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ch_reg    <= CH_VOLT;
            step_reg  <= '0;
        end else begin
            state_reg <= state_next;
            ch_reg    <= ch_next;
            step_reg  <= step_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ch_next    = ch_reg;
        step_next  = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_HPV;
            end
            ST_HPV:   state_next = ST_HPA;
            ST_HPA:   state_next = ST_CAL;
            ST_CAL:   state_next = ST_CALSQ;
            ST_CALSQ: state_next = ST_VSQ;
            ST_VSQ:   state_next = ST_ASQ;
            ST_ASQ:   state_next = ST_PW;
            ST_PW: begin
                if (stat.win_end) begin
                    state_next = ST_DIV_LD;
                    ch_next    = CH_VOLT;
                end else begin
                    state_next = ST_IDLE;
                end
            end
            ST_DIV_LD: state_next = ST_DIV;
            ST_DIV: begin
                if (step_reg == DIV_LAST) begin
                    state_next = (ch_reg == CH_POWER) ? ST_BM1 : ST_SQRT_LD;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_SQRT_LD: state_next = ST_SQRT;
            ST_SQRT: begin
                if (step_reg == SQRT_LAST) begin
                    state_next = ST_RMS_MUL;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_RMS_MUL: state_next = ST_RMS_ST;
            ST_RMS_ST: begin
                state_next = ST_DIV_LD;
                ch_next    = (ch_reg == CH_VOLT) ? CH_AMP : CH_POWER;
            end
            ST_BM1: state_next = ST_BM2;
            ST_BM2: state_next = ST_BM3;
            ST_BM3: state_next = ST_BM4;
            ST_BM4: state_next = ST_BM5;
            ST_BM5: state_next = ST_BM6;
            ST_BM6: state_next = ST_BM7;
            ST_BM7: state_next = ST_RP;
            ST_RP:  state_next = ST_AP1;
            ST_AP1: state_next = ST_AP2;
            ST_AP2: state_next = ST_AP3;
            ST_AP3: state_next = ST_AP4;
            ST_AP4: state_next = ST_APQ;
            ST_APQ: state_next = ST_PFI;
            ST_PFI: state_next = ST_PF;
            ST_PF: begin
                if (step_reg == PF_LAST) begin
                    state_next = ST_OUT;
                end else begin
                    step_next = step_reg + 1'b1;
                end
            end
            ST_OUT: begin
                if (!stat.out_busy) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        cmd.sel = ch_reg;
        cmd.op  = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                cmd.op  = s_valid ? OP_ACCEPT : OP_NONE;
            end
            ST_HPV:     cmd.op = OP_HPV;
            ST_HPA:     cmd.op = OP_HPA;
            ST_CAL:     cmd.op = OP_CAL;
            ST_CALSQ:   cmd.op = OP_CALSQ;
            ST_VSQ:     cmd.op = OP_VSQ;
            ST_ASQ:     cmd.op = OP_ASQ;
            ST_PW:      cmd.op = OP_PW;
            ST_DIV_LD:  cmd.op = OP_DIV_LD;
            ST_DIV:     cmd.op = OP_DIV_STEP;
            ST_SQRT_LD: cmd.op = OP_SQRT_LD;
            ST_SQRT:    cmd.op = OP_SQRT_STEP;
            ST_RMS_MUL: cmd.op = OP_RMS_MUL;
            ST_RMS_ST:  cmd.op = OP_RMS_ST;
            ST_BM1:     cmd.op = OP_BM1;
            ST_BM2:     cmd.op = OP_BM2;
            ST_BM3:     cmd.op = OP_BM3;
            ST_BM4:     cmd.op = OP_BM4;
            ST_BM5:     cmd.op = OP_BM5;
            ST_BM6:     cmd.op = OP_BM6;
            ST_BM7:     cmd.op = OP_BM7;
            ST_RP:      cmd.op = OP_RP;
            ST_AP1:     cmd.op = OP_AP1;
            ST_AP2:     cmd.op = OP_AP2;
            ST_AP3:     cmd.op = OP_AP3;
            ST_AP4:     cmd.op = OP_AP4;
            ST_APQ:     cmd.op = OP_APQ;
            ST_PFI:     cmd.op = OP_PFI;
            ST_PF:      cmd.op = OP_PF_STEP;
            ST_OUT:     cmd.op = stat.out_busy ? OP_NONE : OP_OUT;
            default:    cmd.op = OP_NONE;
        endcase
    end

endmodule

// ===== rtl/acpm_dp.sv =====
module acpm_dp #(
    parameter int unsigned ADC_BITS   = 12,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  acpm_pkg::dp_cmd_t                 cmd,
    output acpm_pkg::dp_stat_t                stat,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [acpm_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic [ADC_BITS-1:0]               s_volt_sample,
    input  logic [ADC_BITS-1:0]               s_amp_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [acpm_pkg::RMS_W-1:0]        m_rms_volts,
    output logic [acpm_pkg::RMS_W-1:0]        m_rms_amps,
    output logic signed [acpm_pkg::RP_W-1:0]  m_real_power,
    output logic [acpm_pkg::AP_W-1:0]         m_apparent_power,
    output logic signed [acpm_pkg::PF_W-1:0]  m_power_factor
);
    import acpm_pkg::*;

    localparam int unsigned HP_BITS = ADC_BITS + 12;
    localparam int unsigned CAL_W   = HP_BITS + 3;
    localparam int unsigned MW      = (HP_BITS + 4 > 30) ? HP_BITS + 4 : 30;
    localparam int unsigned PW2     = 2 * MW;
    localparam int unsigned SUM_W   = PW2 + 1;
    localparam int unsigned CMP_W   = (COUNT_BITS > WL_W) ? COUNT_BITS : WL_W;

    localparam logic signed [PW2-1:0]   HALF14 = PW2'(8192);
    localparam logic signed [PW2-1:0]   HALF15 = PW2'(16384);
    localparam logic signed [PW2-1:0]   HALF16 = PW2'(32768);
    localparam logic signed [PW2-1:0]   HMAX   = PW2'((64'sd1 <<< (HP_BITS - 1)) - 64'sd1);
    localparam logic signed [PW2-1:0]   HMIN   = -HMAX - PW2'(1);
    localparam logic signed [PW2-1:0]   RMSMAX = PW2'(64'hFFFF_FFFF);
    localparam logic [SUM_W-1:0]        SQMAX  = SUM_W'((64'd1 << SQ_W) - 64'd1);
    localparam logic signed [SUM_W-1:0] PSMAX  = SUM_W'((64'sd1 <<< (PS_W - 1)) - 64'sd1);
    localparam logic signed [SUM_W-1:0] PSMIN  = -PSMAX - SUM_W'(1);
    localparam logic [ACC_W-1:0]        HALF40 = ACC_W'(1) << 39;
    localparam logic [ACC_W-1:0]        RPPOS  = (ACC_W'(1) << 55) - ACC_W'(1);
    localparam logic [ACC_W-1:0]        RPNEG  = ACC_W'(1) << 55;
    localparam logic [MAGQ_W-1:0]       APMAX  = (MAGQ_W'(1) << 55) - MAGQ_W'(1);
    localparam logic [PF_W-1:0]         PF_ONE = PF_W'(16384);

    logic [WL_W-1:0]                wl_reg;
    logic [PH_W-1:0]                ph_reg;
    logic [GAIN_W-1:0]              vg_reg, ig_reg;
    logic [ADC_BITS-1:0]            prev_v_reg, prev_a_reg, in_v_reg, in_a_reg;
    logic signed [HP_BITS-1:0]      hpv_reg, hpa_reg, last_v_reg;
    logic signed [CAL_W-1:0]        cal_reg;
    logic [SQ_W-1:0]                vsum_reg, asum_reg;
    logic signed [PS_W-1:0]         psum_reg;
    logic [COUNT_BITS-1:0]          count_reg;
    logic signed [PW2-1:0]          prod_reg;
    logic [MAGQ_W-1:0]              div_reg;
    logic [COUNT_BITS-1:0]          rem_reg;
    logic [SQ_W-1:0]                sq_src_reg;
    logic [ROOT_W+1:0]              srem_reg;
    logic [ROOT_W-1:0]              root_reg;
    logic [RMS_W-1:0]               vr_reg, ir_reg;
    logic [ACC_W-1:0]               acc_reg;
    logic [XP_W-1:0]                xp_reg;
    logic                           neg_reg;
    logic [RP_W-1:0]                rpm_reg, pm_reg;
    logic [AP_W-1:0]                appq_reg;
    logic                           pf_zero_reg, pf_full_reg;
    logic [PH_W-1:0]                q_reg;
    logic                           out_valid_reg;

    logic signed [ADC_BITS:0]       dv, da;
    logic signed [HP_BITS:0]        tv, ta, dh;
    logic signed [MW-1:0]           ma, mb;
    logic signed [PW2-1:0]          yr, cr, rr;
    logic signed [HP_BITS-1:0]      ysat;
    logic signed [CAL_W-1:0]        cal_next;
    logic [SUM_W-1:0]               vadd, aadd;
    logic signed [SUM_W-1:0]        padd;
    logic [COUNT_BITS-1:0]          cnt_new;
    logic [MAGQ_W-1:0]              pmag;
    logic [COUNT_BITS:0]            r2;
    logic                           div_ge;
    logic [ROOT_W+1:0]              r4, trial;
    logic                           sq_ge;
    logic [ACC_W-1:0]               prod_u, racc;
    logic [MAGQ_W-1:0]              appq_w;
    logic [RP_W:0]                  m2;
    logic                           pf_ge;
    logic [PF_W-1:0]                pf_mag;
    logic [RMS_W-1:0]               rms_sat;

    always_comb begin
        dv = $signed({1'b0, s_volt_sample}) - $signed({1'b0, prev_v_reg});
        da = $signed({1'b0, in_a_reg}) - $signed({1'b0, prev_a_reg});
        tv = (HP_BITS+1)'(hpv_reg) + (HP_BITS+1)'($signed({dv, 8'd0}));
        ta = (HP_BITS+1)'(hpa_reg) + (HP_BITS+1)'($signed({da, 8'd0}));
        dh = (HP_BITS+1)'(hpv_reg) - (HP_BITS+1)'(last_v_reg);
    end

    always_comb begin
        ma = '0;
        mb = '0;
        case (cmd.op)
            OP_ACCEPT: begin
                ma = MW'(tv);
                mb = MW'($signed({1'b0, HP_COEF}));
            end
            OP_HPV: begin
                ma = MW'(ta);
                mb = MW'($signed({1'b0, HP_COEF}));
            end
            OP_HPA: begin
                ma = MW'($signed({1'b0, ph_reg}));
                mb = MW'(dh);
            end
            OP_CALSQ: begin
                ma = MW'(cal_reg);
                mb = MW'(cal_reg);
            end
            OP_VSQ: begin
                ma = MW'(hpa_reg);
                mb = MW'(hpa_reg);
            end
            OP_ASQ: begin
                ma = MW'(cal_reg);
                mb = MW'(hpa_reg);
            end
            OP_RMS_MUL: begin
                ma = MW'($signed({1'b0, root_reg}));
                mb = (cmd.sel == CH_VOLT) ? MW'($signed({1'b0, vg_reg}))
                                          : MW'($signed({1'b0, ig_reg}));
            end
            OP_BM1: begin
                ma = MW'($signed({1'b0, div_reg[28:0]}));
                mb = MW'($signed({1'b0, vg_reg}));
            end
            OP_BM2: begin
                ma = MW'($signed({1'b0, div_reg[56:29]}));
                mb = MW'($signed({1'b0, vg_reg}));
            end
            OP_BM4: begin
                ma = MW'($signed({1'b0, xp_reg[26:0]}));
                mb = MW'($signed({1'b0, ig_reg}));
            end
            OP_BM5: begin
                ma = MW'($signed({1'b0, xp_reg[53:27]}));
                mb = MW'($signed({1'b0, ig_reg}));
            end
            OP_BM6: begin
                ma = MW'($signed({1'b0, xp_reg[80:54]}));
                mb = MW'($signed({1'b0, ig_reg}));
            end
            OP_RP: begin
                ma = MW'($signed({1'b0, vr_reg[15:0]}));
                mb = MW'($signed({1'b0, ir_reg[15:0]}));
            end
            OP_AP1: begin
                ma = MW'($signed({1'b0, vr_reg[15:0]}));
                mb = MW'($signed({1'b0, ir_reg[31:16]}));
            end
            OP_AP2: begin
                ma = MW'($signed({1'b0, vr_reg[31:16]}));
                mb = MW'($signed({1'b0, ir_reg[15:0]}));
            end
            OP_AP3: begin
                ma = MW'($signed({1'b0, vr_reg[31:16]}));
                mb = MW'($signed({1'b0, ir_reg[31:16]}));
            end
            default: begin
                ma = '0;
                mb = '0;
            end
        endcase
    end

    always_comb begin
        yr = (prod_reg + HALF15) >>> 15;
        if (yr > HMAX) begin
            ysat = HP_BITS'(HMAX);
        end else if (yr < HMIN) begin
            ysat = HP_BITS'(HMIN);
        end else begin
            ysat = HP_BITS'(yr);
        end
        cr       = (prod_reg + HALF14) >>> 14;
        cal_next = CAL_W'(last_v_reg) + CAL_W'(cr);
        vadd     = SUM_W'($unsigned(prod_reg)) + SUM_W'(vsum_reg);
        aadd     = SUM_W'($unsigned(prod_reg)) + SUM_W'(asum_reg);
        padd     = SUM_W'(prod_reg) + SUM_W'(psum_reg);
        cnt_new  = count_reg + 1'b1;
        pmag     = psum_reg[PS_W-1] ? MAGQ_W'(~psum_reg) + MAGQ_W'(1) : MAGQ_W'(psum_reg);
        r2       = {rem_reg, div_reg[MAGQ_W-1]};
        div_ge   = (r2 >= {1'b0, count_reg});
        r4       = {srem_reg[ROOT_W-1:0], sq_src_reg[SQ_W-1 -: 2]};
        trial    = {root_reg, 2'b01};
        sq_ge    = (r4 >= trial);
        rr       = (prod_reg + HALF16) >>> 16;
        rms_sat  = (rr > RMSMAX) ? '1 : RMS_W'(rr);
        prod_u   = ACC_W'($unsigned(prod_reg));
        racc     = (acc_reg + HALF40) >> 40;
        appq_w   = MAGQ_W'(acc_reg[63:8]) + MAGQ_W'(acc_reg[7]);
        m2       = {pm_reg, 1'b0};
        pf_ge    = (m2 >= (RP_W+1)'(appq_reg));
        pf_mag   = pf_zero_reg ? '0 : (pf_full_reg ? PF_ONE : PF_W'(q_reg));
    end

    assign stat.win_end  = (CMP_W'(cnt_new) >= CMP_W'(wl_reg)) || (cnt_new == '1);
    assign stat.out_busy = out_valid_reg && !m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wl_reg        <= WL_RESET;
            ph_reg        <= PH_RESET;
            vg_reg        <= GAIN_RESET;
            ig_reg        <= GAIN_RESET;
            prev_v_reg    <= '0;
            prev_a_reg    <= '0;
            hpv_reg       <= '0;
            hpa_reg       <= '0;
            vsum_reg      <= '0;
            asum_reg      <= '0;
            psum_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_idx_t'(cfg_index))
                    CFG_WINDOW: wl_reg <= cfg_wdata[WL_W-1:0];
                    CFG_PHASE:  ph_reg <= cfg_wdata[PH_W-1:0];
                    CFG_VGAIN:  vg_reg <= cfg_wdata[GAIN_W-1:0];
                    CFG_IGAIN:  ig_reg <= cfg_wdata[GAIN_W-1:0];
                    default:    wl_reg <= wl_reg;
                endcase
            end
            if (cmd.op == OP_OUT) begin
                out_valid_reg <= 1'b1;
            end else if (out_valid_reg && m_ready) begin
                out_valid_reg <= 1'b0;
            end
            case (cmd.op)
                OP_HPV: begin
                    hpv_reg    <= ysat;
                    prev_v_reg <= in_v_reg;
                end
                OP_HPA: begin
                    hpa_reg    <= ysat;
                    prev_a_reg <= in_a_reg;
                end
                OP_VSQ:  vsum_reg <= (vadd > SQMAX) ? SQ_W'(SQMAX) : SQ_W'(vadd);
                OP_ASQ:  asum_reg <= (aadd > SQMAX) ? SQ_W'(SQMAX) : SQ_W'(aadd);
                OP_PW: begin
                    if (padd > PSMAX) begin
                        psum_reg <= PS_W'(PSMAX);
                    end else if (padd < PSMIN) begin
                        psum_reg <= PS_W'(PSMIN);
                    end else begin
                        psum_reg <= PS_W'(padd);
                    end
                    count_reg <= cnt_new;
                end
                OP_OUT: begin
                    vsum_reg      <= '0;
                    asum_reg      <= '0;
                    psum_reg      <= '0;
                    count_reg     <= '0;
                end
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= PW2'(ma) * PW2'(mb);
        case (cmd.op)
            OP_ACCEPT: begin
                in_v_reg <= s_volt_sample;
                in_a_reg <= s_amp_sample;
            end
            OP_HPV: last_v_reg <= hpv_reg;
            OP_CAL: cal_reg <= cal_next;
            OP_DIV_LD: begin
                rem_reg <= '0;
                neg_reg <= psum_reg[PS_W-1];
                case (cmd.sel)
                    CH_VOLT: div_reg <= MAGQ_W'(vsum_reg);
                    CH_AMP:  div_reg <= MAGQ_W'(asum_reg);
                    default: div_reg <= pmag;
                endcase
            end
            OP_DIV_STEP: begin
                rem_reg <= div_ge ? COUNT_BITS'(r2 - {1'b0, count_reg}) : COUNT_BITS'(r2);
                div_reg <= {div_reg[MAGQ_W-2:0], div_ge};
            end
            OP_SQRT_LD: begin
                sq_src_reg <= div_reg[SQ_W-1:0];
                srem_reg   <= '0;
                root_reg   <= '0;
            end
            OP_SQRT_STEP: begin
                sq_src_reg <= {sq_src_reg[SQ_W-3:0], 2'b00};
                srem_reg   <= sq_ge ? r4 - trial : r4;
                root_reg   <= {root_reg[ROOT_W-2:0], sq_ge};
            end
            OP_RMS_ST: begin
                if (cmd.sel == CH_VOLT) begin
                    vr_reg <= rms_sat;
                end else begin
                    ir_reg <= rms_sat;
                end
            end
            OP_BM1: acc_reg <= '0;
            OP_BM2: acc_reg <= acc_reg + prod_u;
            OP_BM3: begin
                xp_reg  <= XP_W'(acc_reg + (prod_u << 29));
                acc_reg <= '0;
            end
            OP_BM5: acc_reg <= acc_reg + prod_u;
            OP_BM6: acc_reg <= acc_reg + (prod_u << 27);
            OP_BM7: acc_reg <= acc_reg + (prod_u << 54);
            OP_RP: begin
                if (neg_reg) begin
                    rpm_reg <= (racc > RPNEG) ? RP_W'(RPNEG) : RP_W'(racc);
                end else begin
                    rpm_reg <= (racc > RPPOS) ? RP_W'(RPPOS) : RP_W'(racc);
                end
                acc_reg <= '0;
            end
            OP_AP1: acc_reg <= acc_reg + prod_u;
            OP_AP2: acc_reg <= acc_reg + (prod_u << 16);
            OP_AP3: acc_reg <= acc_reg + (prod_u << 16);
            OP_AP4: acc_reg <= acc_reg + (prod_u << 32);
            OP_APQ: appq_reg <= (appq_w > APMAX) ? AP_W'(APMAX) : AP_W'(appq_w);
            OP_PFI: begin
                pf_zero_reg <= (appq_reg == '0);
                pf_full_reg <= (rpm_reg >= RP_W'(appq_reg));
                pm_reg      <= rpm_reg;
                q_reg       <= '0;
            end
            OP_PF_STEP: begin
                pm_reg <= pf_ge ? RP_W'(m2 - (RP_W+1)'(appq_reg)) : RP_W'(m2);
                q_reg  <= {q_reg[PH_W-2:0], pf_ge};
            end
            OP_OUT: begin
                m_rms_volts      <= vr_reg;
                m_rms_amps       <= ir_reg;
                m_real_power     <= neg_reg ? -$signed(rpm_reg) : $signed(rpm_reg);
                m_apparent_power <= appq_reg;
                m_power_factor   <= neg_reg ? -$signed(pf_mag) : $signed(pf_mag);
            end
            default: q_reg <= q_reg;
        endcase
    end

    assign m_valid = out_valid_reg;

endmodule

// ===== rtl/ac_power_rms_meter_core.sv =====
// AC power meter: one voltage/current ADC sample pair per input word on the
// s_ channel (s_valid/s_ready), one measurement word on the m_ channel
// (m_valid/m_ready) at the end of every window of window_length pairs.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata), to be
// written by the user while the block is idle, which the block itself does not
// enforce: 0 window length, 1 phase factor, 2 voltage gain, 3 current gain.
// Each input word is taken only when s_ready is high, in the idle state, and the
// controller then steps one shared 30x30 multiplier through filter, phase
// interpolation and the three squares/products before the next word is taken.
// The word that closes a window adds three 57-step restoring divides by the
// sample count, two 28-step square roots, a 14-step power factor divide and
// multiplier passes for the products, all on the same multiplier and
// one-bit-per-cycle units.
// The result sits in an output register that holds it through a stalled m_ready,
// while later input words are taken and summed; the next result waits for it.
// Reset (aresetn, synchronous, active low) clears filters, sums, counter and
// output valid, and loads the default configuration.
module ac_power_rms_meter_core #(
    parameter int unsigned ADC_BITS   = 12,
    parameter int unsigned COUNT_BITS = 16
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_wr_en,
    input  logic [1:0]                        cfg_index,
    input  logic [acpm_pkg::CFG_W-1:0]        cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [ADC_BITS-1:0]               s_volt_sample,
    input  logic [ADC_BITS-1:0]               s_amp_sample,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [acpm_pkg::RMS_W-1:0]        m_rms_volts,
    output logic [acpm_pkg::RMS_W-1:0]        m_rms_amps,
    output logic signed [acpm_pkg::RP_W-1:0]  m_real_power,
    output logic [acpm_pkg::AP_W-1:0]         m_apparent_power,
    output logic signed [acpm_pkg::PF_W-1:0]  m_power_factor
);
    import acpm_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    acpm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    acpm_dp #(
        .ADC_BITS   (ADC_BITS),
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .s_volt_sample    (s_volt_sample),
        .s_amp_sample     (s_amp_sample),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_rms_volts      (m_rms_volts),
        .m_rms_amps       (m_rms_amps),
        .m_real_power     (m_real_power),
        .m_apparent_power (m_apparent_power),
        .m_power_factor   (m_power_factor)
    );

`ifndef SYNTHESIS
    a_one_word_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while previous word in flight");

    a_pf_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_power_factor <= 16'sd16384) && (m_power_factor >= -16'sd16384))
        else $error("power factor out of range");

    a_pf_zero_apparent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_apparent_power == '0) |-> (m_power_factor == '0))
        else $error("nonzero power factor with zero apparent power");
`endif

endmodule

// ===== test/ac_power_rms_meter_core_tb.sv =====
`default_nettype none

module ac_power_rms_meter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import acpm_pkg::*;

    typedef struct {
        bit [31:0]        volts;
        bit [31:0]        amps;
        bit signed [55:0] real_pw;
        bit [54:0]        app_pw;
        bit signed [15:0] pf;
    } meas_t;

    localparam int        N_DIR     = 16;
    localparam int        WATCHDOG  = 20000;
    localparam longint    HP_MAX    = (64'sd1 <<< 23) - 1;
    localparam bit [63:0] SUM_MAX   = (64'd1 << 56) - 1;
    localparam longint    PSUM_MAX  = (64'sd1 <<< 56) - 1;
    localparam longint    PSUM_MIN  = -(64'sd1 <<< 56);
    localparam bit [63:0] AP_MAX    = (64'd1 << 55) - 1;

    localparam bit [11:0] DIR_V [N_DIR] = '{
        12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd2048, 12'd1, 12'd4094,
        12'hAAA, 12'h555, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd1234, 12'd3000
    };
    localparam bit [11:0] DIR_A [N_DIR] = '{
        12'd0, 12'd4095, 12'd0, 12'd0, 12'd4095, 12'd2048, 12'd1, 12'd1,
        12'h555, 12'hAAA, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd1234, 12'd100
    };

    logic             aclk = 1'b0;
    logic             aresetn = 1'b0;
    logic             cfg_wr_en = 1'b0;
    logic [1:0]       cfg_index = '0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_valid = 1'b0;
    logic             s_ready;
    logic [11:0]      s_volt_sample = '0;
    logic [11:0]      s_amp_sample = '0;
    logic             m_valid;
    logic             m_ready = 1'b0;
    logic [RMS_W-1:0] m_rms_volts;
    logic [RMS_W-1:0] m_rms_amps;
    logic signed [RP_W-1:0] m_real_power;
    logic [AP_W-1:0]  m_apparent_power;
    logic signed [PF_W-1:0] m_power_factor;

    meas_t  meas_q[$];
    int     errors = 0;
    int     words_in = 0;
    int     words_out = 0;
    int     quiet_cycles = 0;
    bit     src_idle_en = 1'b0;
    bit     snk_stall_en = 1'b0;

    bit [15:0] win_len;
    bit [14:0] phase_k;
    bit [23:0] v_gain, i_gain;
    bit [11:0] last_v, last_a;
    longint    v_hp, a_hp, p_sum;
    bit [63:0] v_sum, a_sum;
    int        n_taken;

    ac_power_rms_meter_core uut (.*);

    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        m_ready <= !(snk_stall_en && $urandom_range(99) < 6);
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG) begin
            $display("%t watchdog: no traffic for %0d cycles", $realtime, WATCHDOG);
            $display("ac_power_rms_meter_core_tb: FAIL");
            $finish;
        end
    end

    function automatic void cmp(string nm, longint e, longint g);
        if (e != g) begin
            errors++;
            $display("%t mismatch %s: expected %0d actual %0d", $realtime, nm, e, g);
        end
    endfunction

    always @(posedge aclk) begin
        meas_t e;
        if (aresetn && m_valid && m_ready) begin
            words_out++;
            if (meas_q.size() == 0) begin
                errors++;
                $display("%t unexpected result word, volts %0d", $realtime, m_rms_volts);
            end else begin
                e = meas_q.pop_front();
                cmp("rms_volts", e.volts, m_rms_volts);
                cmp("rms_amps", e.amps, m_rms_amps);
                cmp("real_power", e.real_pw, m_real_power);
                cmp("apparent_power", e.app_pw, m_apparent_power);
                cmp("power_factor", e.pf, m_power_factor);
            end
        end
    end

    function automatic longint dc_block(longint y, bit [11:0] x, bit [11:0] xp);
        longint t;
        t = y + (longint'(x) - longint'(xp)) * 256;
        t = (t * longint'(HP_COEF) + 16384) >>> 15;
        if (t > HP_MAX) t = HP_MAX;
        if (t < -HP_MAX - 1) t = -HP_MAX - 1;
        return t;
    endfunction

    function automatic bit [63:0] floor_sqrt(bit [63:0] n);
        bit [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= r + b) begin
                n -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic bit [31:0] scaled_rms(bit [63:0] sum, int n, bit [23:0] g);
        bit [63:0] v;
        v = (floor_sqrt(sum / n) * g + (64'd1 << 15)) >> 16;
        return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic bit meter_sample(bit [11:0] vs, bit [11:0] as, output meas_t r);
        longint    prev_hp, cal, ip, real_v;
        bit [63:0] mag, rp, app, appq, m, q;
        bit [127:0] p;
        bit        neg;
        prev_hp = v_hp;
        v_hp = dc_block(v_hp, vs, last_v);
        a_hp = dc_block(a_hp, as, last_a);
        last_v = vs;
        last_a = as;
        cal = prev_hp + ((longint'(phase_k) * (v_hp - prev_hp) + 8192) >>> 14);
        ip = a_hp;
        v_sum += 64'(cal * cal);
        if (v_sum > SUM_MAX) v_sum = SUM_MAX;
        a_sum += 64'(ip * ip);
        if (a_sum > SUM_MAX) a_sum = SUM_MAX;
        p_sum += cal * ip;
        if (p_sum > PSUM_MAX) p_sum = PSUM_MAX;
        if (p_sum < PSUM_MIN) p_sum = PSUM_MIN;
        n_taken++;
        if (n_taken < win_len && n_taken < 65535) return 1'b0;

        r.volts = scaled_rms(v_sum, n_taken, v_gain);
        r.amps = scaled_rms(a_sum, n_taken, i_gain);
        neg = p_sum < 0;
        mag = neg ? 64'(-p_sum) : 64'(p_sum);
        p = 128'(mag / n_taken) * 128'(64'(v_gain) * 64'(i_gain)) + (128'd1 << 39);
        rp = (p >> 96 != 0) ? (64'd1 << 56) : 64'(p >> 40);
        if (neg) begin
            if (rp > (64'd1 << 55)) rp = 64'd1 << 55;
            real_v = -longint'(rp);
        end else begin
            if (rp > AP_MAX) rp = AP_MAX;
            real_v = longint'(rp);
        end
        app = 64'(r.volts) * 64'(r.amps);
        appq = (app >> 8) + ((app >> 7) & 64'd1);
        if (appq > AP_MAX) appq = AP_MAX;
        q = 0;
        if (appq != 0) begin
            m = (real_v < 0) ? 64'(-real_v) : 64'(real_v);
            if (m >= appq) begin
                q = 16384;
            end else begin
                for (int k = 0; k < 14; k++) begin
                    m <<= 1;
                    q <<= 1;
                    if (m >= appq) begin
                        m -= appq;
                        q |= 1;
                    end
                end
            end
        end
        r.real_pw = real_v[55:0];
        r.app_pw = appq[54:0];
        r.pf = (real_v < 0) ? -16'(q) : 16'(q);
        v_sum = 0;
        a_sum = 0;
        p_sum = 0;
        n_taken = 0;
        return 1'b1;
    endfunction

    task automatic write_reg(cfg_idx_t idx, bit [23:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        case (idx)
            CFG_WINDOW: win_len = val[15:0];
            CFG_PHASE:  phase_k = val[14:0];
            CFG_VGAIN:  v_gain = val;
            CFG_IGAIN:  i_gain = val;
        endcase
    endtask

    task automatic set_config(bit [15:0] wl, bit [14:0] ph, bit [23:0] vg, bit [23:0] ig);
        write_reg(CFG_WINDOW, 24'(wl));
        write_reg(CFG_PHASE, 24'(ph));
        write_reg(CFG_VGAIN, vg);
        write_reg(CFG_IGAIN, ig);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic drain();
        while (meas_q.size() != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    // typed: push the given expectation instead of the predicted one
    task automatic send(bit [11:0] vs, bit [11:0] as, bit typed = 1'b0, meas_t tr = '{default:0});
        meas_t r;
        if (src_idle_en && $urandom_range(99) < 6) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_volt_sample <= vs;
        s_amp_sample <= as;
        do @(posedge aclk); while (!s_ready);
        words_in++;
        if (meter_sample(vs, as, r)) meas_q.push_back(typed ? tr : r);
    endtask

    task automatic idle_src();
        s_valid <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic bit [11:0] next_sample(int mode, bit [11:0] prev);
        case (mode)
            0: return $urandom_range(1) ? 12'd4095 : 12'd0;
            1: return prev + 12'($urandom_range(64)) - 12'd32;
            default: return 12'($urandom);
        endcase
    endfunction

    function automatic bit [23:0] pick_gain();
        case ($urandom_range(3))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            2: return 24'd65536;
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        bit [11:0] vs, as;
        bit [15:0] wl;
        bit [14:0] ph;
        int        mode;
        win_len = WL_RESET;
        phase_k = PH_RESET;
        v_gain = GAIN_RESET;
        i_gain = GAIN_RESET;
        last_v = 0;
        last_a = 0;
        v_hp = 0;
        a_hp = 0;
        p_sum = 0;
        v_sum = 0;
        a_sum = 0;
        n_taken = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        set_config(16'd1, 15'd16384, 24'd65536, 24'd65536);
        for (int i = 0; i < N_DIR; i++) send(DIR_V[i], DIR_A[i], i == 0);
        idle_src();
        drain();
        set_config(16'd1, 15'd32767, 24'd0, 24'd0);
        for (int i = 0; i < N_DIR; i++) send(DIR_V[i], DIR_A[i], 1'b1);
        idle_src();
        drain();

        // shorten a window that is already under way
        set_config(16'd10, 15'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        for (int i = 0; i < 6; i++) send(12'($urandom), 12'($urandom));
        idle_src();
        drain();
        set_config(16'd3, 15'd0, 24'hFF_FFFF, 24'hFF_FFFF);
        send(12'd4095, 12'd0);
        idle_src();
        drain();

        set_config(16'd0, 15'd20000, 24'd65536, 24'd100000);
        for (int i = 0; i < 5; i++) send(12'($urandom), 12'($urandom));
        idle_src();
        drain();

        // long window at full gain
        set_config(16'd300, 15'd16384, 24'hFF_FFFF, 24'hFF_FFFF);
        for (int i = 0; i < 300; i++) send(12'($urandom), 12'($urandom));
        idle_src();
        drain();

        vs = 12'd2048;
        as = 12'd2048;
        for (int ph_n = 0; ph_n < 12; ph_n++) begin
            case (ph_n % 4)
                0: wl = 16'd1;
                1: wl = 16'($urandom_range(2, 8));
                2: wl = 16'($urandom_range(9, 64));
                default: wl = 16'($urandom_range(0, 200));
            endcase
            case (ph_n % 3)
                0: ph = 15'd0;
                1: ph = 15'd32767;
                default: ph = 15'($urandom);
            endcase
            set_config(wl, ph, pick_gain(), pick_gain());
            src_idle_en = (ph_n != 5);
            snk_stall_en = (ph_n != 5);
            for (int i = 0; i < 128; i++) begin
                mode = $urandom_range(5);
                vs = next_sample(mode, vs);
                as = next_sample(mode, as);
                send(vs, as);
            end
            idle_src();
            drain();
        end

        $display("covered %0d sample words and %0d measurement words", words_in, words_out);
        $display("windows of 0 to 300 samples, gains and phase at both ends");
        if (errors == 0 && meas_q.size() == 0) begin
            $display("ac_power_rms_meter_core_tb: PASS");
        end else begin
            $display("ac_power_rms_meter_core_tb: FAIL");
        end
        $finish;
    end

endmodule

`default_nettype wire
